[sv/lcs_pkg.sv]
// Shared definitions for logic_channel_statistics: command codes,
// field widths and default parameter values.
// No dependencies.
package lcs_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SEL_W          = 4;
    localparam int CMD_W          = 2;
    localparam int TOTAL_W        = 32;
    localparam int MASK_W         = 16;
    localparam int DEF_CHANNELS   = 16;
    localparam int DEF_COUNT_BITS = 32;

    // s_tdata: sample_value, channel_select, zero pad to whole bytes
    localparam int S_DATA_RAW = SAMPLE_W + SEL_W;
    localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
    // m_tdata: activity_mask, toggle_total, high_total, low_total
    localparam int M_DATA_W   = MASK_W + 3 * TOTAL_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

endpackage

[sv/logic_channel_statistics.sv]
// An accepted request passes through the input register, then the result register, to m_tvalid.
// Throughput: one request per cycle; the input register and result register
// advance together whenever the result register is empty or being taken.
// Reset (aresetn low, synchronous): all counts, the activity mask, the stored
// previous sample and both valid flags clear; the first sample after reset
// only primes the previous-sample register.
// Depends on lcs_pkg.
module logic_channel_statistics #(
    parameter int CHANNELS   = lcs_pkg::DEF_CHANNELS,
    parameter int COUNT_BITS = lcs_pkg::DEF_COUNT_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [15:0] sample_value, [19:16] channel_select, [23:20] zero
    input  logic [lcs_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [lcs_pkg::CMD_W-1:0]    s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] activity_mask, [47:16] toggle_total, [79:48] high_total,
    // [111:80] low_total
    output logic [lcs_pkg::M_DATA_W-1:0] m_tdata
);
    import lcs_pkg::*;

    localparam int EXT_W = (CHANNELS > SAMPLE_W) ? CHANNELS : SAMPLE_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    // input register
    logic                in_valid_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SEL_W-1:0]    sel_reg;

    // statistics state
    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic                have_prev_reg, have_prev_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    cnt_t                tog_reg  [CHANNELS];
    cnt_t                high_reg [CHANNELS];
    cnt_t                low_reg  [CHANNELS];
    cnt_t                tog_next [CHANNELS];
    cnt_t                high_next[CHANNELS];
    cnt_t                low_next [CHANNELS];

    // result register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                advance;
    logic                process;
    logic [EXT_W-1:0]    cur_ext;
    logic [EXT_W-1:0]    prev_ext;
    logic [SAMPLE_W-1:0] diff;
    cnt_t                sel_tog, sel_high, sel_low;

    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign cur_ext  = EXT_W'(sample_reg);
    assign prev_ext = EXT_W'(prev_reg);
    assign diff     = prev_reg ^ sample_reg;

    always_comb begin
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        mask_next      = mask_reg;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            tog_next[ch]  = tog_reg[ch];
            high_next[ch] = high_reg[ch];
            low_next[ch]  = low_reg[ch];
        end
        unique case (cmd_reg)
            CMD_SAMPLE: begin
                if (have_prev_reg) begin
                    mask_next = mask_reg | diff;
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        if (cur_ext[ch] != prev_ext[ch]) begin
                            if (tog_reg[ch] != CNT_MAX)
                                tog_next[ch] = tog_reg[ch] + cnt_t'(1);
                        end else if (prev_ext[ch]) begin
                            if (high_reg[ch] != CNT_MAX)
                                high_next[ch] = high_reg[ch] + cnt_t'(1);
                        end else begin
                            if (low_reg[ch] != CNT_MAX)
                                low_next[ch] = low_reg[ch] + cnt_t'(1);
                        end
                    end
                end
                prev_next      = sample_reg;
                have_prev_next = 1'b1;
            end
            CMD_CLEAR: begin
                mask_next = '0;
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    tog_next[ch]  = '0;
                    high_next[ch] = '0;
                    low_next[ch]  = '0;
                end
            end
            default: begin
                // read and the unused code leave the state alone
            end
        endcase
    end

    // selected channel, post-update; out-of-range selects read as zero
    always_comb begin
        sel_tog  = '0;
        sel_high = '0;
        sel_low  = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (int'(sel_reg) == ch) begin
                sel_tog  = tog_next[ch];
                sel_high = high_next[ch];
                sel_low  = low_next[ch];
            end
        end
        out_data_next = {TOTAL_W'(sel_low), TOTAL_W'(sel_high),
                         TOTAL_W'(sel_tog), mask_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            mask_reg      <= '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                tog_reg[ch]  <= '0;
                high_reg[ch] <= '0;
                low_reg[ch]  <= '0;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (process) begin
                prev_reg      <= prev_next;
                have_prev_reg <= have_prev_next;
                mask_reg      <= mask_next;
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    tog_reg[ch]  <= tog_next[ch];
                    high_reg[ch] <= high_next[ch];
                    low_reg[ch]  <= low_next[ch];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg    <= s_tuser;
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            sel_reg    <= s_tdata[SAMPLE_W +: SEL_W];
        end
        if (process) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[dv/logic_channel_statistics_test.sv]
// Self-checking testbench for logic_channel_statistics: directed and random requests
// on the input stream, each result checked against a local predictor of the counters.
// Depends on lcs_pkg and the logic_channel_statistics RTL.
`timescale 1ns / 100ps

module logic_channel_statistics_test;
    import lcs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int               NUM_CH     = DEF_CHANNELS;
    localparam int               ERR_SHOWN  = 10;

    // Same layout as m_tdata, activity_mask in the low bits.
    typedef struct packed {
        logic [TOTAL_W-1:0] low;
        logic [TOTAL_W-1:0] high;
        logic [TOTAL_W-1:0] toggle;
        logic [MASK_W-1:0]  mask;
    } stat_report_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]    s_tuser  = CMD_READ;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    logic_channel_statistics u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predicted state of the block
    logic [TOTAL_W-1:0]  toggle_cnt [NUM_CH];
    logic [TOTAL_W-1:0]  high_cnt   [NUM_CH];
    logic [TOTAL_W-1:0]  low_cnt    [NUM_CH];
    logic [SAMPLE_W-1:0] held_sample  = '0;
    bit                  held_valid   = 1'b0;
    logic [MASK_W-1:0]   seen_toggles = '0;

    stat_report_t        stats_due_q[$];

    bit                  sender_gaps_on   = 1'b0;
    bit                  receiver_stall_on = 1'b0;
    int                  stall_left       = 0;
    int                  mismatches       = 0;
    int                  results_checked  = 0;
    int                  n_samples        = 0;
    int                  n_reads          = 0;
    int                  n_clears         = 0;
    logic [SAMPLE_W-1:0] drive_prev       = '0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", stats_due_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] c);
        return (c == '1) ? c : c + TOTAL_W'(1);
    endfunction

    function automatic void clear_counters();
        for (int ch = 0; ch < NUM_CH; ch++) begin
            toggle_cnt[ch] = '0;
            high_cnt[ch]   = '0;
            low_cnt[ch]    = '0;
        end
        seen_toggles = '0;
    endfunction

    function automatic stat_report_t predict_statistics(input logic [CMD_W-1:0] cmd,
                                                        input logic [SAMPLE_W-1:0] bits,
                                                        input logic [SEL_W-1:0] sel);
        logic [SAMPLE_W-1:0] diff;
        stat_report_t        rpt;
        if (cmd == CMD_SAMPLE) begin
            if (held_valid) begin
                diff = held_sample ^ bits;
                seen_toggles |= diff;
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    if (diff[ch])
                        toggle_cnt[ch] = sat_inc(toggle_cnt[ch]);
                    else if (held_sample[ch])
                        high_cnt[ch] = sat_inc(high_cnt[ch]);
                    else
                        low_cnt[ch] = sat_inc(low_cnt[ch]);
                end
            end
            held_sample = bits;
            held_valid  = 1'b1;
        end else if (cmd == CMD_CLEAR) begin
            clear_counters();
        end
        rpt.mask   = seen_toggles;
        rpt.toggle = toggle_cnt[sel];
        rpt.high   = high_cnt[sel];
        rpt.low    = low_cnt[sel];
        return rpt;
    endfunction

    // One request; s_tvalid stays high afterwards so the next call can stream on.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] bits,
                                input logic [SEL_W-1:0] sel);
        if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_DATA_W - S_DATA_RAW){1'b0}}, sel, bits};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        stats_due_q.push_back(predict_statistics(cmd, bits, sel));
        case (cmd)
            CMD_SAMPLE: n_samples++;
            CMD_CLEAR:  n_clears++;
            default:    n_reads++;
        endcase
    endtask

    // Hold off the sender until every outstanding result is back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (stats_due_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver backpressure in bursts, started at random while receiver_stall_on is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (receiver_stall_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 12);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void note_mismatch(input string what, input logic [TOTAL_W-1:0] want,
                                          input logic [TOTAL_W-1:0] got);
        mismatches++;
        if (mismatches <= ERR_SHOWN)
            $display("Mismatch on %s at %0t: expected 0x%08h, got 0x%08h",
                     what, $realtime, want, got);
    endfunction

    always @(posedge aclk) begin
        stat_report_t got;
        stat_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = stat_report_t'(m_tdata);
            if (stats_due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= ERR_SHOWN)
                    $display("Unexpected result at %0t: 0x%h", $realtime, m_tdata);
            end else begin
                want = stats_due_q.pop_front();
                results_checked++;
                if (got.mask !== want.mask)
                    note_mismatch("activity_mask", TOTAL_W'(want.mask), TOTAL_W'(got.mask));
                if (got.toggle !== want.toggle)
                    note_mismatch("toggle_total", want.toggle, got.toggle);
                if (got.high !== want.high)
                    note_mismatch("high_total", want.high, got.high);
                if (got.low !== want.low)
                    note_mismatch("low_total", want.low, got.low);
            end
        end
    end

    // Extremes, every command and the corner cases: empty state, first sample,
    // clear keeping the previous sample, unused command code.
    task automatic test_directed();
        send_request(CMD_READ, 16'h0000, 4'd0);        // nothing counted yet
        send_request(CMD_CLEAR, 16'hFFFF, 4'd15);      // clear on empty state
        send_request(CMD_UNUSED, 16'h1234, 4'd9);      // behaves as a read
        send_request(CMD_SAMPLE, 16'hFFFF, 4'd0);      // first sample only primes
        send_request(CMD_SAMPLE, 16'hFFFF, 4'd15);     // all steady high
        send_request(CMD_SAMPLE, 16'h0000, 4'd7);      // all toggle
        send_request(CMD_SAMPLE, 16'h0000, 4'd3);      // all steady low
        send_request(CMD_SAMPLE, 16'hAAAA, 4'd1);
        send_request(CMD_SAMPLE, 16'h5555, 4'd2);
        send_request(CMD_SAMPLE, 16'h8001, 4'd15);
        send_request(CMD_SAMPLE, 16'h8001, 4'd0);
        send_request(CMD_READ, 16'hFFFF, 4'd15);
        send_request(CMD_READ, 16'h0000, 4'd8);
        send_request(CMD_CLEAR, 16'h0000, 4'd5);       // reports zeros
        send_request(CMD_SAMPLE, 16'h8001, 4'd15);     // still paired with 8001
        send_request(CMD_SAMPLE, 16'h7FFE, 4'd0);
        send_request(CMD_UNUSED, 16'hFFFF, 4'd15);
        send_request(CMD_SAMPLE, 16'h7FFE, 4'd14);
        send_request(CMD_READ, 16'h0000, 4'd4);
        drive_prev = 16'h7FFE;
    endtask

    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 84) return CMD_SAMPLE;
        if (r < 94) return CMD_READ;
        if (r < 98) return CMD_CLEAR;
        return CMD_UNUSED;
    endfunction

    // Mixed commands, mostly samples with varied toggle density: random, single-bit flips, repeats, sparse flips.
    task automatic test_random_traffic(input int n);
        logic [SAMPLE_W-1:0] bits;
        logic [CMD_W-1:0]    cmd;
        for (int i = 0; i < n; i++) begin
            cmd = pick_command();
            case ($urandom_range(0, 3))
                0:       bits = SAMPLE_W'($urandom);
                1:       bits = drive_prev ^ (16'h1 << $urandom_range(0, SAMPLE_W - 1));
                2:       bits = drive_prev;
                default: bits = drive_prev ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
            endcase
            if (cmd == CMD_SAMPLE) drive_prev = bits;
            send_request(cmd, bits, SEL_W'($urandom_range(0, NUM_CH - 1)));
        end
    endtask

    // Long stretches of a held value with occasional reads, as slow signals look.
    task automatic test_steady_runs(input int n);
        int                  run_left;
        logic [SAMPLE_W-1:0] bits;
        run_left = 0;
        bits     = drive_prev;
        for (int i = 0; i < n; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(1, 30);
                bits     = SAMPLE_W'($urandom);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0) begin
                send_request(CMD_READ, SAMPLE_W'($urandom),
                             SEL_W'($urandom_range(0, NUM_CH - 1)));
            end else begin
                drive_prev = bits;
                send_request(CMD_SAMPLE, bits, SEL_W'($urandom_range(0, NUM_CH - 1)));
            end
        end
    endtask

    initial begin
        clear_counters();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        wait_for_results();

        sender_gaps_on    = 1'b1;
        receiver_stall_on = 1'b1;
        test_random_traffic(800);
        wait_for_results();

        sender_gaps_on = 1'b0;
        test_steady_runs(200);
        sender_gaps_on    = 1'b1;
        receiver_stall_on = 1'b0;
        test_steady_runs(200);
        wait_for_results();

        // Final stretch streams back to back on both sides
        sender_gaps_on    = 1'b0;
        receiver_stall_on = 1'b0;
        test_random_traffic(430);

        wait_for_results();
        repeat (8) @(posedge aclk);
        $display("Requests sent: %0d samples, %0d reads, %0d clears; %0d results compared",
                 n_samples, n_reads, n_clears, results_checked);
        $display("Mismatches or stray results: %0d", mismatches);
        if (mismatches == 0 && stats_due_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
